/* rtl/awu_pkg.sv */
// Shared types and codes for the accumulator with undo history.
package awu_pkg;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_UNDO = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DIVZERO = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_SAT     = 2'd3;

  typedef enum logic [2:0] {
    AS_IDLE, AS_MUL, AS_MULFIN, AS_DIV, AS_DIVFIN, AS_DONE
  } alu_state_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_UNDO, ST_CALC, ST_DONE
  } top_state_e;

  typedef struct packed {
    logic       start;
    logic [2:0] mode;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

endpackage

/* rtl/accumulator_with_undo_stack_unit.sv */
// Top level: running Q32.32 total with an undo history held in RAM.
//
// Input stream: s_axis_tuser_i carries the command (add, subtract, multiply,
// divide, undo), s_axis_tdata_i the signed Q32.32 operand. Each request gives
// exactly one result on the output stream: tdata holds the new total and the
// history count, tuser the status (ok, divide by zero, undo on empty,
// saturated).
// One request is processed at a time. Multiply forms four 32x32 partial
// products through one multiplier; divide produces one quotient bit per cycle
// over 96 bits. Refused commands (undo on empty, divide by zero) skip the
// arithmetic and go straight to the result.
// The history RAM is read ahead for undo and written on each push;
// the current total lives in a register, so no RAM read is needed otherwise.
// After reset the history is empty and the total reads as zero; RAM contents
// need no clearing. A stalled receiver holds the result register; one more
// request is accepted and computed meanwhile, then waits for the slot.
module accumulator_with_undo_stack_unit #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // operand[63:0]
  input  logic [2:0]  s_axis_tuser_i,   // mode[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [((64 + $clog2(HISTORY_DEPTH + 1) + 7) / 8) * 8 - 1:0]
                      m_axis_tdata_o,   // total[63:0], history_count above it
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int OW = ((64 + CW + 7) / 8) * 8;

  awu_pkg::top_state_e state_q, state_d;
  logic [AW-1:0] top_q, top_d, top_inc, top_dec;
  logic [CW-1:0] count_q, count_d;
  logic [63:0]   cur_q, cur_d;
  logic [63:0]   res_q, res_d;
  logic [1:0]    stat_q, stat_d;
  logic          mvalid_q, mvalid_d;
  logic [63:0]   mtotal_q, mtotal_d;
  logic [1:0]    mstat_q, mstat_d;
  logic [CW-1:0] mcount_q, mcount_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  awu_pkg::alu_req_t alu_req;
  awu_pkg::alu_rsp_t alu_rsp;
  logic [63:0]       alu_res;
  logic              accept, out_free;

  assign top_inc  = (top_q == AW'(HISTORY_DEPTH - 1)) ? '0 : top_q + AW'(1);
  assign top_dec  = (top_q == '0) ? AW'(HISTORY_DEPTH - 1) : top_q - AW'(1);
  assign accept   = s_axis_tvalid_i && (state_q == awu_pkg::ST_IDLE);
  assign out_free = !mvalid_q || m_axis_tready_i;

  awu_ram #(.Width(64), .Depth(HISTORY_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  awu_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (cur_q),
    .b_i      (s_axis_tdata_i),
    .rsp_o    (alu_rsp),
    .result_o (alu_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      awu_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == awu_pkg::MODE_UNDO) begin
            state_d = (count_q == '0) ? awu_pkg::ST_DONE : awu_pkg::ST_UNDO;
          end else if (s_axis_tuser_i == awu_pkg::MODE_DIV && s_axis_tdata_i == '0) begin
            state_d = awu_pkg::ST_DONE;
          end else begin
            state_d = awu_pkg::ST_CALC;
          end
        end
      end
      awu_pkg::ST_UNDO: state_d = awu_pkg::ST_DONE;
      awu_pkg::ST_CALC: if (alu_rsp.done) state_d = awu_pkg::ST_DONE;
      awu_pkg::ST_DONE: if (out_free) state_d = awu_pkg::ST_IDLE;
      default:          state_d = awu_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    top_d = top_q; count_d = count_q; cur_d = cur_q;
    res_d = res_q; stat_d = stat_q;
    mtotal_d = mtotal_q; mstat_d = mstat_q; mcount_d = mcount_q;
    mvalid_d = mvalid_q && !m_axis_tready_i;
    ram_we = 1'b0; ram_re = 1'b0;
    ram_waddr = top_inc; ram_raddr = top_dec; ram_wdata = alu_res;
    alu_req.start = 1'b0;
    alu_req.mode  = s_axis_tuser_i;
    s_axis_tready_o = (state_q == awu_pkg::ST_IDLE);
    unique case (state_q)
      awu_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i == awu_pkg::MODE_UNDO) begin
            if (count_q == '0) begin
              res_d  = '0;
              stat_d = awu_pkg::STAT_EMPTY;
            end else begin
              // fetch the entry below the top
              top_d   = top_dec;
              count_d = count_q - CW'(1);
              ram_re  = 1'b1;
            end
          end else if (s_axis_tuser_i == awu_pkg::MODE_DIV && s_axis_tdata_i == '0) begin
            res_d  = cur_q;
            stat_d = awu_pkg::STAT_DIVZERO;
          end else begin
            alu_req.start = 1'b1;
          end
        end
      end
      awu_pkg::ST_UNDO: begin
        cur_d  = (count_q == '0) ? '0 : ram_rdata;
        res_d  = cur_d;
        stat_d = awu_pkg::STAT_OK;
      end
      awu_pkg::ST_CALC: begin
        if (alu_rsp.done) begin
          res_d   = alu_res;
          stat_d  = alu_rsp.sat ? awu_pkg::STAT_SAT : awu_pkg::STAT_OK;
          cur_d   = alu_res;
          top_d   = top_inc;
          ram_we  = 1'b1;
          if (count_q != CW'(HISTORY_DEPTH)) count_d = count_q + CW'(1);
        end
      end
      awu_pkg::ST_DONE: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          mtotal_d = res_q;
          mstat_d  = stat_q;
          mcount_d = count_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = OW'({mcount_q, mtotal_q});
  assign m_axis_tuser_o  = mstat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= awu_pkg::ST_IDLE;
      top_q    <= '0;
      count_q  <= '0;
      cur_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      count_q  <= count_d;
      cur_q    <= cur_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    stat_q   <= stat_d;
    mtotal_q <= mtotal_d;
    mstat_q  <= mstat_d;
    mcount_q <= mcount_d;
  end

endmodule

/* rtl/awu_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module awu_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/awu_alu.sv */
// Q32.32 arithmetic unit: add/sub computed at start, 4-step multiply, bit-serial divide.
module awu_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  awu_pkg::alu_req_t  req_i,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  output awu_pkg::alu_rsp_t  rsp_o,
  output logic [63:0]        result_o
);

  awu_pkg::alu_state_e state_q, state_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         neg_q, neg_d;
  logic [63:0]  ua_q, ua_d, ub_q, ub_d;
  logic [127:0] acc_q, acc_d;
  logic [95:0]  num_q, num_d;
  logic [63:0]  rem_q, rem_d, quo_q, quo_d;
  logic         big_q, big_d;
  logic [63:0]  res_q, res_d;
  logic         sat_q, sat_d;

  logic [63:0]  mag_a, mag_b, sum, dif;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [64:0]  rem_sh, lim_mul, lim_div;

  function automatic logic [64:0] sat_limit(logic [63:0] mag, logic big, logic neg);
    logic [63:0] lim;
    logic [63:0] m;
    logic        s;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    s = big || (mag > lim);
    m = s ? lim : mag;
    return {s, neg ? (~m + 64'd1) : m};
  endfunction

  assign mag_a  = a_i[63] ? (~a_i + 64'd1) : a_i;
  assign mag_b  = b_i[63] ? (~b_i + 64'd1) : b_i;
  assign sum    = a_i + b_i;
  assign dif    = a_i - b_i;
  assign mul_a  = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign mul_b  = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
  assign prod   = 64'(mul_a) * 64'(mul_b);
  assign rem_sh = {rem_q, num_q[95]};
  assign lim_mul = sat_limit(acc_q[95:32], |acc_q[127:96], neg_q);
  assign lim_div = sat_limit(quo_q, big_q, neg_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      awu_pkg::AS_IDLE: begin
        if (req_i.start) begin
          if (req_i.mode == awu_pkg::MODE_MUL) state_d = awu_pkg::AS_MUL;
          else if (req_i.mode == awu_pkg::MODE_DIV) state_d = awu_pkg::AS_DIV;
          else state_d = awu_pkg::AS_DONE;
        end
      end
      awu_pkg::AS_MUL:    if (cnt_q == 7'd3) state_d = awu_pkg::AS_MULFIN;
      awu_pkg::AS_DIV:    if (cnt_q == 7'd95) state_d = awu_pkg::AS_DIVFIN;
      awu_pkg::AS_MULFIN: state_d = awu_pkg::AS_DONE;
      awu_pkg::AS_DIVFIN: state_d = awu_pkg::AS_DONE;
      awu_pkg::AS_DONE:   state_d = awu_pkg::AS_IDLE;
      default:            state_d = awu_pkg::AS_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d = cnt_q; neg_d = neg_q; ua_d = ua_q; ub_d = ub_q; acc_d = acc_q;
    num_d = num_q; rem_d = rem_q; quo_d = quo_q; big_d = big_q;
    res_d = res_q; sat_d = sat_q;
    unique case (state_q)
      awu_pkg::AS_IDLE: begin
        if (req_i.start) begin
          neg_d = a_i[63] ^ b_i[63];
          ua_d  = mag_a;
          ub_d  = mag_b;
          cnt_d = '0;
          acc_d = '0;
          num_d = {mag_a, 32'd0};
          rem_d = '0;
          quo_d = '0;
          big_d = 1'b0;
          sat_d = 1'b0;
          res_d = a_i;
          case (req_i.mode)
            awu_pkg::MODE_ADD: begin
              if (!(a_i[63] ^ b_i[63]) && (sum[63] ^ a_i[63])) begin
                sat_d = 1'b1;
                res_d = a_i[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
              end else begin
                res_d = sum;
              end
            end
            awu_pkg::MODE_SUB: begin
              if ((a_i[63] ^ b_i[63]) && (dif[63] ^ a_i[63])) begin
                sat_d = 1'b1;
                res_d = a_i[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
              end else begin
                res_d = dif;
              end
            end
            default: ;
          endcase
        end
      end
      awu_pkg::AS_MUL: begin
        acc_d = acc_q + (128'(prod) << (7'd32 * (7'(cnt_q[0]) + 7'(cnt_q[1]))));
        cnt_d = cnt_q + 7'd1;
      end
      awu_pkg::AS_DIV: begin
        num_d = {num_q[94:0], 1'b0};
        if (quo_q[63]) big_d = 1'b1;
        if (rem_sh >= {1'b0, ub_q}) begin
          rem_d = 64'(rem_sh - {1'b0, ub_q});
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh[63:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
      end
      awu_pkg::AS_MULFIN: begin
        res_d = lim_mul[63:0];
        sat_d = lim_mul[64];
      end
      awu_pkg::AS_DIVFIN: begin
        res_d = lim_div[63:0];
        sat_d = lim_div[64];
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.done = (state_q == awu_pkg::AS_DONE);
    rsp_o.sat  = sat_q;
    result_o   = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= awu_pkg::AS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d; neg_q <= neg_d; ua_q <= ua_d; ub_q <= ub_d; acc_q <= acc_d;
    num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d; big_q <= big_d;
    res_q <= res_d; sat_q <= sat_d;
  end

endmodule

/* tb/sv/tb_accumulator_with_undo_stack_unit.sv */
// Testbench for the accumulator with undo history: random and directed requests, scoreboard check.
`timescale 1ns / 100ps

module tb_accumulator_with_undo_stack_unit;

  localparam int DEPTH = 64;
  localparam int OW = ((64 + $clog2(DEPTH + 1) + 7) / 8) * 8;
  localparam logic [63:0] SIGN_B = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_P  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] operand;
  } request_t;

  typedef struct packed {
    logic [63:0] total;
    logic [1:0]  status;
    logic [6:0]  count;
  } outcome_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [63:0]   s_axis_tdata_i = '0;
  logic [2:0]    s_axis_tuser_i = '0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [OW-1:0] m_axis_tdata_o;
  logic [1:0]    m_axis_tuser_o;

  accumulator_with_undo_stack_unit #(.HISTORY_DEPTH(DEPTH)) uut (.*);

  always #2 clk_i = ~clk_i;

  request_t    pending_q[$];
  outcome_t    expected_q[$];
  logic [63:0] hist_ring[DEPTH];
  int          ring_top = 0;
  int          ring_count = 0;
  int          mismatches = 0;
  int          hold_cycles = 0;
  bit          feed_done = 0;
  bit          in_taken = 0;

  function automatic logic [63:0] mag_of(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] apply_sign(logic [63:0] m, bit big, bit neg, ref bit sat);
    logic [63:0] lim;
    lim = neg ? SIGN_B : MAX_P;
    if (big || m > lim) begin
      sat = 1;
      m = lim;
    end
    return neg ? (~m + 64'd1) : m;
  endfunction

  function automatic outcome_t accumulate(request_t rq);
    outcome_t    o;
    logic [63:0] cur, res, ua, ub, rem, quo;
    logic [127:0] prod, num;
    bit          sat, neg, big, carry;
    cur = ring_count == 0 ? 64'd0 : hist_ring[ring_top];
    res = cur;
    sat = 0;
    o.status = awu_pkg::STAT_OK;
    if (rq.mode == awu_pkg::MODE_UNDO) begin
      if (ring_count == 0) o.status = awu_pkg::STAT_EMPTY;
      else begin
        ring_top = (ring_top + DEPTH - 1) % DEPTH;
        ring_count--;
      end
      res = ring_count == 0 ? 64'd0 : hist_ring[ring_top];
    end else if (rq.mode == awu_pkg::MODE_DIV && rq.operand == 0) begin
      o.status = awu_pkg::STAT_DIVZERO;
    end else begin
      neg = cur[63] ^ rq.operand[63];
      ua = mag_of(cur);
      ub = mag_of(rq.operand);
      case (rq.mode)
        awu_pkg::MODE_ADD: begin
          res = cur + rq.operand;
          if (cur[63] == rq.operand[63] && res[63] != cur[63]) begin
            sat = 1;
            res = cur[63] ? SIGN_B : MAX_P;
          end
        end
        awu_pkg::MODE_SUB: begin
          res = cur - rq.operand;
          if (cur[63] != rq.operand[63] && res[63] != cur[63]) begin
            sat = 1;
            res = cur[63] ? SIGN_B : MAX_P;
          end
        end
        awu_pkg::MODE_MUL: begin
          prod = {64'd0, ua} * {64'd0, ub};
          res = apply_sign(prod[95:32], prod[127:96] != 0, neg, sat);
        end
        awu_pkg::MODE_DIV: begin
          num = {32'd0, ua, 32'd0};
          rem = 0;
          quo = 0;
          big = 0;
          for (int i = 127; i >= 0; i--) begin
            carry = rem[63];
            rem = {rem[62:0], num[i]};
            if (carry || rem >= ub) begin
              rem = rem - ub;
              if (quo[63]) big = 1;
              quo = {quo[62:0], 1'b1};
            end else begin
              if (quo[63]) big = 1;
              quo = {quo[62:0], 1'b0};
            end
          end
          res = apply_sign(quo, big, neg, sat);
        end
        default: res = cur;
      endcase
      ring_top = (ring_top + 1) % DEPTH;
      hist_ring[ring_top] = res;
      if (ring_count < DEPTH) ring_count++;
      if (sat) o.status = awu_pkg::STAT_SAT;
    end
    o.total = res;
    o.count = 7'(ring_count);
    return o;
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return MAX_P;
      2: return SIGN_B;
      3: return 64'($signed($urandom_range(0, 40)) - 20) << 32;
      4: return {{32{1'b0}}, $urandom()} ^ (64'($urandom_range(0, 1)) << 63) >>> 0;
      5: return 64'(signed'(int'($urandom_range(0, 8)) - 4)) <<< 31;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic push_request(logic [2:0] m, logic [63:0] v);
    request_t rq;
    rq.mode = m;
    rq.operand = v;
    pending_q.push_back(rq);
  endtask

  // Note the request handshake at the rising edge where it happens.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
  end

  // Driver: offer queued requests with random gaps.
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        expected_q.push_back(accumulate(pending_q.pop_front()));
        gap_left = $urandom_range(0, 9) == 0 ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i <= pending_q[0].mode;
        s_axis_tdata_i <= pending_q[0].operand;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver readiness, with a forced long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= $urandom_range(0, 9) == 0 ? 1'b0 : 1'b1;
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.total = m_axis_tdata_o[63:0];
      got.count = m_axis_tdata_o[70:64];
      got.status = m_axis_tuser_o;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: total %h/%h status %0d/%0d count %0d/%0d",
                     want.total, got.total, want.status, got.status, want.count, got.count);
        end
      end
    end
  end

  initial begin
    logic [2:0] m;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // Directed: empty undo, divide by zero, extremes, saturation, unused modes.
    push_request(awu_pkg::MODE_UNDO, 64'd0);
    push_request(awu_pkg::MODE_DIV, 64'd0);
    push_request(awu_pkg::MODE_ADD, MAX_P);
    push_request(awu_pkg::MODE_ADD, 64'd1);
    push_request(awu_pkg::MODE_MUL, 64'h2_0000_0000);
    push_request(awu_pkg::MODE_SUB, SIGN_B);
    push_request(awu_pkg::MODE_UNDO, 64'd0);
    push_request(awu_pkg::MODE_DIV, 64'h0000_0000_0000_0001);
    push_request(awu_pkg::MODE_DIV, 64'hFFFF_FFFF_FFFF_FFFF);
    push_request(awu_pkg::MODE_SUB, MAX_P);
    push_request(awu_pkg::MODE_SUB, 64'd5);
    push_request(awu_pkg::MODE_MUL, SIGN_B);
    push_request(3'd5, 64'd7);
    push_request(3'd6, SIGN_B);
    push_request(3'd7, MAX_P);
    push_request(awu_pkg::MODE_DIV, 64'h3_0000_0000);
    push_request(awu_pkg::MODE_DIV, 64'd0);
    for (int i = 0; i < 8; i++) push_request(awu_pkg::MODE_UNDO, 64'd0);
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    // Fill history past its depth so it wraps, then undo past empty; receiver holds off at first.
    hold_cycles = 400;
    for (int i = 0; i < 70; i++)
      push_request(awu_pkg::MODE_ADD, 64'($urandom_range(1, 9)) << 32);
    for (int i = 0; i < 70; i++) push_request(awu_pkg::MODE_UNDO, 64'd0);
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    for (int i = 0; i < 560; i++) begin
      m = $urandom_range(0, 9) < 3 ? awu_pkg::MODE_UNDO : 3'($urandom_range(0, 3));
      if ($urandom_range(0, 40) == 0) m = 3'($urandom_range(5, 7));
      push_request(m, rand_operand());
      if (i % 50 == 49) wait (pending_q.size() == 0);
    end
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) $display("tb_accumulator_with_undo_stack_unit OK");
    else $display("tb_accumulator_with_undo_stack_unit NOT OK");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_accumulator_with_undo_stack_unit NOT OK");
    $finish;
  end

endmodule
